[rtl/core/mtg_pkg.sv]
// ----------------------------------------------------------------------------
// mtg_pkg
// shared types, constants and word functions of the mt19937 generator
// ----------------------------------------------------------------------------
package mtg_pkg;

    localparam int unsigned STATE_WORDS  = 624;
    localparam int unsigned TWIST_OFFSET = 397;
    localparam int unsigned ADDR_W       = 10;
    localparam int unsigned WORD_W       = 32;

    localparam logic [31:0] MT_MATRIX    = 32'h9908_b0df;
    localparam logic [31:0] MT_UPPER     = 32'h8000_0000;
    localparam logic [31:0] MT_LOWER     = 32'h7fff_ffff;
    localparam logic [31:0] MT_INIT_MULT = 32'd1812433253;
    localparam logic [31:0] MT_TEMPER_B  = 32'h9d2c_5680;
    localparam logic [31:0] MT_TEMPER_C  = 32'hefc6_0000;
    localparam logic [31:0] SEED_RESET   = 32'd5489;

    // action codes of an input beat
    localparam logic ACT_DRAW = 1'b0;
    localparam logic ACT_SEED = 1'b1;

    // classified item handed from the front to the back
    typedef struct packed {
        logic        is_seed;
        logic [31:0] seed;
    } t_item;

    // twist of one word from the current, next and far words
    function automatic logic [31:0] twist_word(input logic [31:0] cur,
                                               input logic [31:0] nxt,
                                               input logic [31:0] far);
        logic [31:0] v;
        v = (cur & MT_UPPER) | (nxt & MT_LOWER);
        return far ^ (v >> 1) ^ (nxt[0] ? MT_MATRIX : 32'h0);
    endfunction

    // output tempering
    function automatic logic [31:0] temper(input logic [31:0] y_in);
        logic [31:0] y;
        y = y_in;
        y = y ^ (y >> 11);
        y = y ^ ((y << 7) & MT_TEMPER_B);
        y = y ^ ((y << 15) & MT_TEMPER_C);
        y = y ^ (y >> 18);
        return y;
    endfunction

endpackage

[rtl/core/mtg_ram.sv]
// ----------------------------------------------------------------------------
// mtg_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module mtg_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 624
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/core/mtg_front.sv]
// ----------------------------------------------------------------------------
// mtg_front
// input beat acceptance, action decode and two-entry item queue
// ----------------------------------------------------------------------------
module mtg_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  logic          i_action,
    input  logic [31:0]   i_seed_value,
    output logic          o_item_valid,
    output mtg_pkg::t_item o_item,
    input  logic          i_item_ready
);

    mtg_pkg::t_item r_q [2];
    logic           r_wr_ptr;
    logic           r_rd_ptr;
    logic [1:0]     r_count;
    logic [1:0]     n_count;
    logic           push;
    logic           pop;
    mtg_pkg::t_item item_in;

    always_comb begin
        item_in.is_seed = (i_action == mtg_pkg::ACT_SEED);
        item_in.seed    = i_seed_value;
    end

    assign o_ready      = (r_count != 2'd2);
    assign push         = i_valid && o_ready;
    assign o_item_valid = (r_count != 2'd0);
    assign pop          = o_item_valid && i_item_ready;
    assign o_item       = r_q[r_rd_ptr];

    always_comb begin
        n_count = r_count;
        if (push && !pop) begin
            n_count = r_count + 2'd1;
        end else if (pop && !push) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr_ptr] <= item_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            r_count <= n_count;
        end
    end

endmodule

[rtl/core/mtg_back.sv]
// ----------------------------------------------------------------------------
// mtg_back
// state sequencer: seeding fill, per-draw twist and tempering, result beat
// ----------------------------------------------------------------------------
module mtg_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cfg_we,
    input  logic [31:0]    i_cfg_wdata,
    input  logic           i_item_valid,
    input  mtg_pkg::t_item i_item,
    output logic           o_item_ready,
    output logic           o_valid,
    output logic [31:0]    o_random_word,
    input  logic           i_ready
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_FILL = 2'd1;
    localparam logic [1:0] ST_CALC = 2'd2;

    localparam logic [mtg_pkg::ADDR_W-1:0] LAST_ADDR =
        mtg_pkg::ADDR_W'(mtg_pkg::STATE_WORDS - 1);

    logic [1:0]                 r_state;
    logic [1:0]                 n_state;
    logic [31:0]                r_default_seed;
    logic                       r_seeded;
    logic [mtg_pkg::ADDR_W-1:0] r_pos;
    logic [mtg_pkg::ADDR_W-1:0] r_fill_idx;
    logic [31:0]                r_fill_word;
    logic [31:0]                r_cur;
    logic                       r_out_valid;
    logic [31:0]                r_out_word;

    logic                       out_free;
    logic                       start_fill;
    logic [31:0]                fill_seed;
    logic                       start_draw;
    logic [31:0]                fill_mix;
    logic [31:0]                fill_prod;
    logic [31:0]                n_fill_word;
    logic [mtg_pkg::ADDR_W-1:0] nxt_addr;
    logic [mtg_pkg::ADDR_W:0]   far_sum;
    logic [mtg_pkg::ADDR_W-1:0] far_addr;
    logic [mtg_pkg::ADDR_W-1:0] pos_next;
    logic [31:0]                nxt_word;
    logic [31:0]                far_word;
    logic [31:0]                twisted;
    logic                       ram_we;
    logic [mtg_pkg::ADDR_W-1:0] ram_waddr;
    logic [31:0]                ram_wdata;

    // item decisions in idle
    assign out_free   = !r_out_valid || i_ready;
    assign start_fill = (r_state == ST_IDLE) && i_item_valid
                        && (i_item.is_seed || !r_seeded);
    assign start_draw = (r_state == ST_IDLE) && i_item_valid
                        && !i_item.is_seed && r_seeded && out_free;
    assign fill_seed  = i_item.is_seed ? i_item.seed : r_default_seed;
    // a draw before any seed keeps its item queued while the fill runs
    assign o_item_ready = (r_state == ST_IDLE) && i_item_valid
                          && (i_item.is_seed || start_draw);

    // seeding recurrence, one word per cycle
    assign fill_mix    = r_fill_word ^ (r_fill_word >> 30);
    assign fill_prod   = mtg_pkg::MT_INIT_MULT * fill_mix;
    assign n_fill_word = fill_prod
                         + {{(32 - mtg_pkg::ADDR_W){1'b0}}, r_fill_idx + 1'b1};

    // read addresses for the word at the read position
    assign pos_next = (r_pos == LAST_ADDR) ? '0 : r_pos + 1'b1;
    assign nxt_addr = pos_next;
    assign far_sum  = {1'b0, r_pos} + (mtg_pkg::ADDR_W + 1)'(mtg_pkg::TWIST_OFFSET);
    assign far_addr = (far_sum >= (mtg_pkg::ADDR_W + 1)'(mtg_pkg::STATE_WORDS))
        ? mtg_pkg::ADDR_W'(far_sum - (mtg_pkg::ADDR_W + 1)'(mtg_pkg::STATE_WORDS))
        : mtg_pkg::ADDR_W'(far_sum);

    assign twisted = mtg_pkg::twist_word(r_cur, nxt_word, far_word);

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_pos;
        ram_wdata = twisted;
        if (r_state == ST_FILL) begin
            ram_we    = 1'b1;
            ram_waddr = r_fill_idx;
            ram_wdata = r_fill_word;
        end else if (r_state == ST_CALC) begin
            ram_we    = 1'b1;
        end
    end

    // two copies of the state, one per read address
    mtg_ram #(
        .WIDTH (mtg_pkg::WORD_W),
        .DEPTH (mtg_pkg::STATE_WORDS)
    ) u_ram_nxt (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (nxt_addr),
        .o_rdata (nxt_word)
    );

    mtg_ram #(
        .WIDTH (mtg_pkg::WORD_W),
        .DEPTH (mtg_pkg::STATE_WORDS)
    ) u_ram_far (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (far_addr),
        .o_rdata (far_word)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (start_fill) begin
                    n_state = ST_FILL;
                end else if (start_draw) begin
                    n_state = ST_CALC;
                end
            end
            ST_FILL: begin
                if (r_fill_idx == LAST_ADDR) begin
                    n_state = ST_IDLE;
                end
            end
            ST_CALC: begin
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (start_fill) begin
            r_fill_word <= fill_seed;
            r_fill_idx  <= '0;
        end else if (r_state == ST_FILL) begin
            r_fill_word <= n_fill_word;
            r_fill_idx  <= r_fill_idx + 1'b1;
        end
        if (r_state == ST_FILL && r_fill_idx == '0) begin
            r_cur <= r_fill_word;
        end else if (r_state == ST_CALC) begin
            r_cur <= nxt_word;
        end
        if (r_state == ST_CALC) begin
            r_out_word <= mtg_pkg::temper(twisted);
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= ST_IDLE;
            r_default_seed <= mtg_pkg::SEED_RESET;
            r_seeded       <= 1'b0;
            r_pos          <= '0;
            r_out_valid    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_default_seed <= i_cfg_wdata;
            end
            if (r_state == ST_FILL && r_fill_idx == LAST_ADDR) begin
                r_seeded <= 1'b1;
                r_pos    <= '0;
            end else if (r_state == ST_CALC) begin
                r_pos <= pos_next;
            end
            if (r_state == ST_CALC) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_valid       = r_out_valid;
    assign o_random_word = r_out_word;

endmodule

[rtl/core/mt19937_generator_top.sv]
// ----------------------------------------------------------------------------
// mt19937_generator_top
// 32-bit mt19937 random word source with seed and draw beats
// ----------------------------------------------------------------------------
// a draw beat taken in idle reads the state ram, whose read is registered;
//   calc twists and writes back that word and registers it tempered;
//   the next draw is taken only in idle, with the result register free
// a seed beat is taken in idle, then the fill state writes all 624 state
//   words with one multiply per word
// reset clears control only; the state ram holds garbage until the first
//   seed, and a draw before any seed first fills from default_seed
// ----------------------------------------------------------------------------
module mt19937_generator_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration: default seed register
    input  logic        i_cfg_we,
    input  logic [31:0] i_cfg_wdata,
    // input beats
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_action,
    input  logic [31:0] i_seed_value,
    // result beats
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [31:0] o_random_word
);

    // queue between the front and the back end
    logic           item_valid;
    logic           item_ready;
    mtg_pkg::t_item item;

    // front: accepts beats, decodes the action and buffers two items so
    // that up to two input beats are still taken while the back end is busy
    mtg_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_in_valid),
        .o_ready      (o_in_ready),
        .i_action     (i_action),
        .i_seed_value (i_seed_value),
        .o_item_valid (item_valid),
        .o_item       (item),
        .i_item_ready (item_ready)
    );

    // back: two state ram copies (next word and far word read ports), the
    // seeding sequencer and the per-draw twist; each draw twists exactly the
    // word it returns, so words are twisted in place in draw order and no
    // separate block regeneration pass is needed
    mtg_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_item_valid  (item_valid),
        .i_item        (item),
        .o_item_ready  (item_ready),
        .o_valid       (o_out_valid),
        .o_random_word (o_random_word),
        .i_ready       (i_out_ready)
    );

endmodule
